// ===== rtl/core/idle_power_state_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Idle power state controller: assertion macros
// Immediate-consequence and next-cycle property macros; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef IDLE_POWER_STATE_CONTROLLER_UNIT_DEFINES_SVH
`define IDLE_POWER_STATE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define IPSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IPSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define IPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/ipsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Idle power state controller package
// Shared widths, codes, reset values, word types and the dim level function.
// ----------------------------------------------------------------------------
package ipsc_pkg;

    localparam int LevelWidth    = 8;
    localparam int TimeWidth     = 24;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 24;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ACTIVITY   = 2'd1,
        OP_FORCE      = 2'd2,
        OP_BRIGHTNESS = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_ACTIVE = 2'd0,
        ST_DIM    = 2'd1,
        ST_OFF    = 2'd2,
        ST_DEEP   = 2'd3
    } pstate_t;

    localparam logic [CfgIndexWidth-1:0] REG_ACTIVE_BRIGHTNESS  = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_SLEEP_TIMEOUT      = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_DIM_TIMEOUT        = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_DEEP_SLEEP_TIMEOUT = 3'd3;

    localparam logic [LevelWidth-1:0] BRIGHTNESS_RST = 8'd128;
    localparam logic [TimeWidth-1:0]  SLEEP_TO_RST   = 24'd60000;
    localparam logic [TimeWidth-1:0]  DIM_TO_RST     = 24'd15000;
    localparam logic [TimeWidth-1:0]  DEEP_TO_RST    = 24'd300000;
    localparam logic [TimeWidth-1:0]  IDLE_MAX       = {TimeWidth{1'b1}};
    localparam logic [LevelWidth-1:0] DIM_FLOOR      = 8'd5;

    typedef struct packed {
        logic [LevelWidth-1:0] active_brightness;
        logic [TimeWidth-1:0]  sleep_timeout;
        logic [TimeWidth-1:0]  dim_timeout;
        logic [TimeWidth-1:0]  deep_sleep_timeout;
    } cfg_t;

    typedef struct packed {
        pstate_t               mode;
        logic [TimeWidth-1:0]  idle_count;
        logic [LevelWidth-1:0] shown_level;
        logic [LevelWidth-1:0] kept_level;
        logic                  radio_mode;
        logic                  ui_dark;
    } ctx_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [1:0]            forced_state;
        logic [LevelWidth-1:0] brightness_level;
        logic                  external_power;
    } cmd_t;

    typedef struct packed {
        logic [1:0]            power_state;
        logic [LevelWidth-1:0] display_brightness;
        logic [LevelWidth-1:0] stored_brightness;
        logic                  radio_save;
        logic                  ui_asleep;
        logic                  deep_sleep_request;
    } rsp_t;

    // x * 25 / 100 is exactly x / 4
    function automatic logic [LevelWidth-1:0] dim_level(input logic [LevelWidth-1:0] ab);
        logic [LevelWidth-1:0] q;
        q = {2'b00, ab[LevelWidth-1:2]};
        return (q < DIM_FLOOR) ? DIM_FLOOR : q;
    endfunction

endpackage

// ===== rtl/core/ipsc_if.sv =====
// ----------------------------------------------------------------------------
// Idle power state controller channels
// Command and status channels, valid/ready with the payload fields.
// ----------------------------------------------------------------------------
interface ipsc_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     opcode;
    logic [1:0]                     forced_state;
    logic [ipsc_pkg::LevelWidth-1:0] brightness_level;
    logic                           external_power;

    modport source (output valid, output opcode, output forced_state,
                    output brightness_level, output external_power, input ready);
    modport sink   (input valid, input opcode, input forced_state,
                    input brightness_level, input external_power, output ready);
endinterface

interface ipsc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     power_state;
    logic [ipsc_pkg::LevelWidth-1:0] display_brightness;
    logic [ipsc_pkg::LevelWidth-1:0] stored_brightness;
    logic                           radio_save;
    logic                           ui_asleep;
    logic                           deep_sleep_request;

    modport source (output valid, output power_state, output display_brightness,
                    output stored_brightness, output radio_save, output ui_asleep,
                    output deep_sleep_request, input ready);
    modport sink   (input valid, input power_state, input display_brightness,
                    input stored_brightness, input radio_save, input ui_asleep,
                    input deep_sleep_request, output ready);
endinterface

// ===== rtl/core/idle_power_state_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Idle power state controller
// Four-state display and radio power control driven by command words.
// ----------------------------------------------------------------------------
// Usage: command words (tick, activity, force state, set brightness) enter on
// cmd; each produces exactly one status word on status, in order.
// Config registers are written via cfg_we/cfg_index/cfg_data; unknown indices
// are dropped. Users write only while no word is in flight (not enforced).
// Order: a taken command is registered, then stepped against the context into
// the status register once status may advance; it is shown from then on.
// Throughput: one word per cycle unless status is held; the step is one pass
// of compare and select logic between the command and status registers.
// Reset: state active, idle count zero, both levels 128, radio balanced,
// ui awake, registers at their default values, both stages empty.
// Stall: when status is held, the command register still takes one word;
// after that cmd.ready drops until status is taken. No word is dropped.
// ----------------------------------------------------------------------------
`include "idle_power_state_controller_unit_defines.svh"

module idle_power_state_controller_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ipsc_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [ipsc_pkg::CfgDataWidth-1:0]  cfg_data,
    ipsc_cmd_if.sink                          cmd,
    ipsc_rsp_if.source                        status
);
    import ipsc_pkg::*;

    cfg_t cfg;
    ctx_t ctx_reg;
    ctx_t ctx_next;
    ctx_t ctx_step;
    cmd_t cmd_reg;
    cmd_t cmd_in;
    rsp_t rsp_reg;
    rsp_t rsp_step;
    logic cmd_valid_reg;
    logic cmd_valid_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic advance;
    logic cmd_fire;

    ipsc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    ipsc_step u_step (
        .cfg     (cfg),
        .ctx     (ctx_reg),
        .cmd     (cmd_reg),
        .ctx_out (ctx_step),
        .rsp     (rsp_step)
    );

    assign cmd_in.opcode           = cmd.opcode;
    assign cmd_in.forced_state     = cmd.forced_state;
    assign cmd_in.brightness_level = cmd.brightness_level;
    assign cmd_in.external_power   = cmd.external_power;

    assign advance   = !rsp_valid_reg || status.ready;
    assign cmd.ready = !cmd_valid_reg || advance;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        cmd_valid_next = cmd_fire || (cmd_valid_reg && !advance);
        rsp_valid_next = advance ? cmd_valid_reg : rsp_valid_reg;
        ctx_next       = (advance && cmd_valid_reg) ? ctx_step : ctx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg       <= 1'b0;
            rsp_valid_reg       <= 1'b0;
            ctx_reg.mode        <= ST_ACTIVE;
            ctx_reg.idle_count  <= '0;
            ctx_reg.shown_level <= BRIGHTNESS_RST;
            ctx_reg.kept_level  <= BRIGHTNESS_RST;
            ctx_reg.radio_mode  <= 1'b0;
            ctx_reg.ui_dark     <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            ctx_reg       <= ctx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_reg <= cmd_in;
        end
        if (advance && cmd_valid_reg)
        begin
            rsp_reg <= rsp_step;
        end
    end

    assign status.valid              = rsp_valid_reg;
    assign status.power_state        = rsp_reg.power_state;
    assign status.display_brightness = rsp_reg.display_brightness;
    assign status.stored_brightness  = rsp_reg.stored_brightness;
    assign status.radio_save         = rsp_reg.radio_save;
    assign status.ui_asleep          = rsp_reg.ui_asleep;
    assign status.deep_sleep_request = rsp_reg.deep_sleep_request;

    `IPSC_ASSERT_NOW(a_radio_ui_match, clk, rst_n, 1'b1, ctx_reg.radio_mode == ctx_reg.ui_dark, "radio and ui flags disagree")
    `IPSC_ASSERT_NOW(a_off_saves_radio, clk, rst_n, ctx_reg.mode == ST_OFF || ctx_reg.mode == ST_DEEP, ctx_reg.radio_mode, "screen off without radio saving")
    `IPSC_ASSERT_NEXT(a_activity_clears, clk, rst_n, advance && cmd_valid_reg && cmd_reg.opcode == OP_ACTIVITY, ctx_reg.idle_count == '0, "idle count not cleared by activity")
    `IPSC_ASSERT_NOW(a_full_blocks, clk, rst_n, rsp_valid_reg && !status.ready && cmd_valid_reg, !cmd.ready, "command taken with both stages full")

endmodule

// ===== rtl/core/ipsc_cfg.sv =====
// ----------------------------------------------------------------------------
// Idle power state controller configuration registers
// Write-only register file; indices beyond the last register are ignored.
// ----------------------------------------------------------------------------
module ipsc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [ipsc_pkg::CfgIndexWidth-1:0] index,
    input  logic [ipsc_pkg::CfgDataWidth-1:0]  data,
    output ipsc_pkg::cfg_t                    cfg
);
    import ipsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                REG_ACTIVE_BRIGHTNESS:  cfg_next.active_brightness  = data[LevelWidth-1:0];
                REG_SLEEP_TIMEOUT:      cfg_next.sleep_timeout      = data[TimeWidth-1:0];
                REG_DIM_TIMEOUT:        cfg_next.dim_timeout        = data[TimeWidth-1:0];
                REG_DEEP_SLEEP_TIMEOUT: cfg_next.deep_sleep_timeout = data[TimeWidth-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_brightness  <= BRIGHTNESS_RST;
            cfg_reg.sleep_timeout      <= SLEEP_TO_RST;
            cfg_reg.dim_timeout        <= DIM_TO_RST;
            cfg_reg.deep_sleep_timeout <= DEEP_TO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/ipsc_step.sv =====
// ----------------------------------------------------------------------------
// Idle power state controller step logic
// Next context and status word for one command word.
// ----------------------------------------------------------------------------
module ipsc_step (
    input  ipsc_pkg::cfg_t cfg,
    input  ipsc_pkg::ctx_t ctx,
    input  ipsc_pkg::cmd_t cmd,
    output ipsc_pkg::ctx_t ctx_out,
    output ipsc_pkg::rsp_t rsp
);
    import ipsc_pkg::*;

    logic [TimeWidth-1:0] idle_inc;
    logic                 pulse;
    ctx_t                 nx;

    assign idle_inc = (ctx.idle_count == IDLE_MAX) ? ctx.idle_count
                                                   : ctx.idle_count + 1'b1;

    always_comb
    begin
        nx    = ctx;
        pulse = 1'b0;
        unique case (opcode_t'(cmd.opcode))
            OP_TICK:
            begin
                nx.idle_count = idle_inc;
                unique case (ctx.mode)
                    ST_ACTIVE, ST_DIM:
                    begin
                        if (idle_inc > cfg.sleep_timeout)
                        begin
                            nx.mode        = ST_OFF;
                            nx.shown_level = '0;
                            nx.radio_mode  = 1'b1;
                            nx.ui_dark     = 1'b1;
                        end
                        else if (ctx.mode == ST_ACTIVE && idle_inc > cfg.dim_timeout)
                        begin
                            nx.mode        = ST_DIM;
                            nx.shown_level = dim_level(cfg.active_brightness);
                        end
                    end
                    ST_OFF:
                    begin
                        if (idle_inc > cfg.deep_sleep_timeout && !cmd.external_power)
                        begin
                            nx.mode        = ST_DEEP;
                            nx.shown_level = '0;
                            pulse          = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_ACTIVITY:
            begin
                nx.idle_count = '0;
                if (ctx.mode != ST_ACTIVE)
                begin
                    nx.mode        = ST_ACTIVE;
                    nx.kept_level  = cfg.active_brightness;
                    nx.shown_level = cfg.active_brightness;
                    // on activity, only a wake from screen off or deep sleep restores radio and ui
                    if (ctx.mode == ST_OFF || ctx.mode == ST_DEEP)
                    begin
                        nx.radio_mode = 1'b0;
                        nx.ui_dark    = 1'b0;
                    end
                end
            end
            OP_FORCE:
            begin
                nx.mode = pstate_t'(cmd.forced_state);
                unique case (pstate_t'(cmd.forced_state))
                    ST_ACTIVE:
                    begin
                        nx.shown_level = cfg.active_brightness;
                        nx.radio_mode  = 1'b0;
                        nx.ui_dark     = 1'b0;
                    end
                    ST_DIM:
                    begin
                        nx.shown_level = dim_level(cfg.active_brightness);
                    end
                    default:
                    begin
                        nx.shown_level = '0;
                        nx.radio_mode  = 1'b1;
                        nx.ui_dark     = 1'b1;
                    end
                endcase
            end
            default:
            begin
                nx.kept_level  = cmd.brightness_level;
                nx.shown_level = cmd.brightness_level;
            end
        endcase
    end

    assign ctx_out                = nx;
    assign rsp.power_state        = nx.mode;
    assign rsp.display_brightness = nx.shown_level;
    assign rsp.stored_brightness  = nx.kept_level;
    assign rsp.radio_save         = nx.radio_mode;
    assign rsp.ui_asleep          = nx.ui_dark;
    assign rsp.deep_sleep_request = pulse;

endmodule
